// File: src/hset_pkg.sv
// Shared types, opcodes and sizing constants for the bucketed hash set.
`default_nettype none

package hset_pkg;

  // Key and request field widths.
  localparam int KEY_W = 32;
  localparam int OP_W  = 2;

  // The bucket remainder runs as a short pipeline of fixed length.
  localparam int MOD_STEPS = 3;
  localparam int CNT_W     = 2;

  // Default table geometry.
  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 8;

  // Request opcodes; the unused code behaves as a query.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_EXISTS = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write one cleared row and advance the sweep
    logic load;      // capture an incoming request
    logic mod_step;  // one step of the bucket remainder
    logic rd;        // read the selected bucket row
    logic upd;       // write back the row and present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the sweep is on its final row
    logic mod_last;  // the remainder is on its final step
    logic out_free;  // the result register can take a new beat
  } sts_t;

endpackage

`default_nettype wire

// File: src/hset_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module hset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/hset_ctrl.sv
// Controller state machine sequencing clear, remainder, read and update.
`default_nettype none

module hset_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hset_pkg::sts_t sts,
  output hset_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // Hold the read row until the result register has room.
        if (sts.out_free) begin
          cmd.upd    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // A write-back must never overrun a result that is still waiting.
  a_upd_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> sts.out_free)
    else $error("row update issued while result register is occupied");

  // The sweep hands over to normal service right after its final row.
  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) && sts.clr_last |=> !in_stall)
    else $error("clearing pass did not end after its final row");

endmodule

`default_nettype wire

// File: src/hset_dp.sv
// Datapath: request registers, bucket remainder, way compare and row update.
`default_nettype none

module hset_dp #(
  parameter int BUCKETS = hset_pkg::BUCKETS_DEF,
  parameter int WAYS    = hset_pkg::WAYS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire hset_pkg::cmd_t               cmd,
  output hset_pkg::sts_t                    sts,
  input  wire logic [hset_pkg::OP_W-1:0]    op,
  input  wire logic signed [hset_pkg::KEY_W-1:0] key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              was_present,
  output logic                              status
);

  localparam int AddrW = $clog2(BUCKETS);
  localparam int SlotW = hset_pkg::KEY_W + 1;
  localparam int RowW  = WAYS * SlotW;
  localparam int ProdW = 2 * hset_pkg::KEY_W;

  // Bucket count and floor(2^32 / BUCKETS) for the reciprocal remainder.
  localparam logic [hset_pkg::KEY_W-1:0] BktMul = hset_pkg::KEY_W'(BUCKETS);
  localparam logic [hset_pkg::KEY_W-1:0] Recip  =
    hset_pkg::KEY_W'((64'd1 << hset_pkg::KEY_W) / BUCKETS);
  localparam logic [AddrW-1:0] BktLast  = AddrW'(BUCKETS - 1);
  localparam logic [hset_pkg::CNT_W-1:0] CntLast =
    hset_pkg::CNT_W'(hset_pkg::MOD_STEPS - 1);

  logic [hset_pkg::OP_W-1:0]  op_r;
  logic [hset_pkg::KEY_W-1:0] key_r;
  logic [hset_pkg::KEY_W-1:0] mag;
  logic [AddrW-1:0]           rem;
  logic [hset_pkg::CNT_W-1:0] cnt;
  logic [AddrW-1:0]           clr_addr;

  logic [hset_pkg::KEY_W-1:0] key_bits;
  logic [hset_pkg::KEY_W-1:0] key_mag;
  logic [ProdW-1:0]           prod;
  logic [hset_pkg::KEY_W-1:0] qd;
  logic [hset_pkg::KEY_W-1:0] diff;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RowW-1:0]  ram_wdata;
  logic [RowW-1:0]  rdata;

  logic [WAYS-1:0] way_valid;
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] first_hit;
  logic [WAYS-1:0] first_free;
  logic            hit;
  logic            full;
  logic            is_ins;
  logic            is_del;
  logic            row_change;
  logic [RowW-1:0] row_new;

  // Magnitude of a two's complement key; the most negative key maps to 2^31.
  assign key_bits = key;
  assign key_mag  = key_bits[hset_pkg::KEY_W-1] ? (~key_bits + 32'd1) : key_bits;

  // The quotient estimate from the reciprocal is exact or one short, so the
  // difference below lies under twice the bucket count.
  assign diff = mag - qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      cnt      <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.mod_step) begin
        cnt <= cnt + hset_pkg::CNT_W'(1);
      end
    end
  end

  // Three remainder stages run together; each is valid one step after the
  // one before it, so the bucket index is settled after the final step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      key_r <= key_bits;
      mag   <= key_mag;
    end else if (cmd.mod_step) begin
      prod <= ProdW'(mag) * ProdW'(Recip);
      qd   <= prod[ProdW-1:hset_pkg::KEY_W] * BktMul;
      rem  <= (diff >= BktMul) ? AddrW'(diff - BktMul) : AddrW'(diff);
    end
  end

  hset_ram #(
    .WIDTH (RowW),
    .DEPTH (BUCKETS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (rem),
    .rdata (rdata)
  );

  // Compare every way of the fetched row against the request key.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = rdata[w*SlotW + hset_pkg::KEY_W];
      hit_vec[w]   = way_valid[w] &&
                     (rdata[w*SlotW +: hset_pkg::KEY_W] == key_r);
    end
  end

  assign first_hit  = hit_vec & (~hit_vec + WAYS'(1));
  assign first_free = ~way_valid & (way_valid + WAYS'(1));
  assign hit        = |hit_vec;
  assign full       = &way_valid;
  assign is_ins     = (op_r == hset_pkg::OP_INSERT);
  assign is_del     = (op_r == hset_pkg::OP_DELETE);
  assign row_change = (is_ins && !hit && !full) || (is_del && hit);

  always_comb begin
    row_new = rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (is_ins && !hit && first_free[w]) begin
        row_new[w*SlotW +: SlotW] = {1'b1, key_r};
      end else if (is_del && first_hit[w]) begin
        row_new[w*SlotW +: SlotW] = '0;
      end
    end
  end

  assign ram_we    = cmd.clr_step || (cmd.upd && row_change);
  assign ram_waddr = cmd.clr_step ? clr_addr : rem;
  assign ram_wdata = cmd.clr_step ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      was_present <= hit;
      status      <= is_ins && !hit && full;
    end
  end

  assign sts.clr_last = (clr_addr == BktLast);
  assign sts.mod_last = (cnt == CntLast);
  assign sts.out_free = !out_valid || !out_stall;

  // A result only appears as the outcome of a row update.
  a_result_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.upd))
    else $error("result beat appeared without a row update");

  // The clearing sweep and a request write-back never share the write port.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_step && (cmd.upd || cmd.load || cmd.mod_step)))
    else $error("clearing pass overlapped request processing");

endmodule

`default_nettype wire

// File: src/hash_set_insert_delete_lookup_top.sv
// Top level of the bucketed hash set with insert, delete and membership query.
`default_nettype none

// A set of signed 32-bit keys held in BUCKETS buckets of WAYS slots each.
// Every request beat carries an op (insert, delete or exists; the unused
// code behaves as exists) and a key, and yields exactly one result beat
// telling whether the key was present before the request. The bucket is
// the key's magnitude modulo BUCKETS, where the most negative key counts as
// 2^31. An insert fills the lowest free way of its bucket; when the bucket
// is full and the key absent, the insert is dropped and status is 1.
// After reset the block sweeps the whole store to empty, one bucket row per
// cycle, and stalls its input until the sweep ends; only then is the first
// request taken. Each request then passes through capture, three steps of
// the bucket remainder (a multiply by the reciprocal of BUCKETS, a
// multiply back, then a compare and subtract), the registered row read
// and the compare and write-back, which loads its result. After that
// write-back the next request can be accepted in the following cycle.
// A finished result sits in an output register, so a new request is
// accepted while the previous result still waits to be taken; the
// write-back of that new request waits only if the earlier beat is
// still stalled at that point.
module hash_set_insert_delete_lookup_top #(
  parameter int BUCKETS = hset_pkg::BUCKETS_DEF,
  parameter int WAYS    = hset_pkg::WAYS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hset_pkg::OP_W-1:0]         op,
  input  wire logic signed [hset_pkg::KEY_W-1:0] key,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   was_present,
  output logic                                   status
);

  // Command and status bundles between the controller and the datapath.
  hset_pkg::cmd_t cmd;
  hset_pkg::sts_t sts;

  // The controller owns the input handshake and the sequence of steps.
  hset_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the request, the store and the result register.
  hset_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .was_present (was_present),
    .status      (status)
  );

endmodule

`default_nettype wire
